// ----- sv/nrmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, constants and helper functions for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // Line and number format
  localparam int LINE_LIMIT  = 1024;
  localparam int POS_W       = $clog2(LINE_LIMIT + 1);
  localparam int FRAC_DIGITS = 4;
  localparam int FRAC_W      = 3;
  localparam int SCALE_W     = 20;        // holds 10^6
  localparam int DIGITS      = 6;
  localparam int DIG_W       = 4 * DIGITS;

  localparam int LAT_W = 27;
  localparam int LON_W = 30;
  localparam int MAC_W = LON_W + 4;
  localparam logic [LAT_W-1:0] LAT_MAX = LAT_W'(99999999);
  localparam logic [LON_W-1:0] LON_MAX = LON_W'(999999999);

  localparam logic [3:0] COMMA_MAX = 4'd15;

  // Byte positions and field numbers
  localparam int TYPE_POS   = 5;
  localparam int TIME_POS0  = 7;
  localparam logic [3:0] LAT_FIELD  = 4'd3;
  localparam logic [3:0] NS_FIELD   = 4'd4;
  localparam logic [3:0] LON_FIELD  = 4'd5;
  localparam logic [3:0] EW_FIELD   = 4'd6;
  localparam logic [3:0] DATE_FIELD = 4'd9;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;

  // Configuration
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_ZONE_HOURS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ADD_SECOND = 2'd1;
  localparam logic [4:0] ZONE_RESET = 5'd8;
  localparam logic [4:0] HOUR_MAX   = 5'd23;

  localparam int OUT_BITS = 111;
  localparam int OUT_W    = 112;
  localparam logic [11:0] YEAR_BASE = 12'd2000;

  // Raw record handed from the parser to the time/date unit
  typedef struct packed {
    logic [DIG_W-1:0] time_dig;
    logic [DIG_W-1:0] date_dig;
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic [FRAC_W-1:0] frac;
    logic             scale_lat;
    logic             scale_lon;
    logic [7:0]       ns;
    logic [7:0]       ew;
  } rec_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [3:0] d;
    d = (c >= CH_0 && c <= CH_9) ? c[3:0] : 4'd0;
    return d;
  endfunction

  function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [SCALE_W-1:0] p;
    unique case (k)
      3'd0:    p = SCALE_W'(1);
      3'd1:    p = SCALE_W'(10);
      3'd2:    p = SCALE_W'(100);
      3'd3:    p = SCALE_W'(1000);
      3'd4:    p = SCALE_W'(10000);
      3'd5:    p = SCALE_W'(100000);
      3'd6:    p = SCALE_W'(1000000);
      default: p = SCALE_W'(1);
    endcase
    return p;
  endfunction

  // Factor that pads a number out to FRAC_DIGITS fraction digits
  function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] fc);
    logic [SCALE_W-1:0] p;
    p = pow10(FRAC_W'(FRAC_DIGITS) - fc);
    return p;
  endfunction

  // Two stored digits to a value, clamped at mx
  function automatic logic [6:0] two_dig(input logic [3:0] hi, input logic [3:0] lo,
                                         input logic [6:0] mx);
    logic [7:0] v;
    v = 8'(hi) * 8'd10 + 8'(lo);
    return (v > 8'(mx)) ? mx : v[6:0];
  endfunction

endpackage

// ----- sv/nrmc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_front
// Byte parser: line position, comma count, digits and position accumulators.
// ----------------------------------------------------------------------------
module nrmc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output nrmc_pkg::rec_t      q_rec
);

  logic [nrmc_pkg::POS_W-1:0]  line_pos_r, line_pos_nxt;
  logic [3:0]                  comma_r, comma_nxt;
  logic [nrmc_pkg::POS_W-1:0]  field_off_r, field_off_nxt;
  logic                        type_c_r, type_c_nxt;
  logic [nrmc_pkg::DIG_W-1:0]  time_r, time_nxt;
  logic [nrmc_pkg::DIG_W-1:0]  date_r, date_nxt;
  logic [nrmc_pkg::LAT_W-1:0]  lat_r, lat_nxt;
  logic [nrmc_pkg::LON_W-1:0]  lon_r, lon_nxt;
  logic [nrmc_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic                        in_frac_r, in_frac_nxt;
  logic                        stop_r, stop_nxt;
  logic [7:0]                  ns_r, ns_nxt;
  logic [7:0]                  ew_r, ew_nxt;

  logic       fire;
  logic       active;
  logic       is_digit;
  logic [3:0] dig;

  // shared pad-out multiplier, used when a position field closes
  logic [nrmc_pkg::LON_W-1:0]                  sc_op;
  logic [nrmc_pkg::LON_W+nrmc_pkg::SCALE_W-1:0] sc_prod;
  logic [nrmc_pkg::LAT_W-1:0]                  lat_scaled;
  logic [nrmc_pkg::LON_W-1:0]                  lon_scaled;

  logic [nrmc_pkg::MAC_W-1:0] lat_mac, lon_mac;
  logic [nrmc_pkg::LAT_W-1:0] lat_mac_sat;
  logic [nrmc_pkg::LON_W-1:0] lon_mac_sat;
  logic                       num_take;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign active   = line_pos_r < nrmc_pkg::POS_W'(nrmc_pkg::LINE_LIMIT);
  assign is_digit = (in_byte >= nrmc_pkg::CH_0) && (in_byte <= nrmc_pkg::CH_9);
  assign dig      = nrmc_pkg::digit_of(in_byte);

  assign sc_op   = (comma_r == nrmc_pkg::LAT_FIELD) ? nrmc_pkg::LON_W'(lat_r) : lon_r;
  assign sc_prod = (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(sc_op) *
                   (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::frac_scale(frac_r));
  assign lat_scaled = (sc_prod > (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::LAT_MAX)) ?
                      nrmc_pkg::LAT_MAX : sc_prod[nrmc_pkg::LAT_W-1:0];
  assign lon_scaled = (sc_prod > (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::LON_MAX)) ?
                      nrmc_pkg::LON_MAX : sc_prod[nrmc_pkg::LON_W-1:0];

  assign lat_mac = nrmc_pkg::MAC_W'(lat_r) * nrmc_pkg::MAC_W'(10) + nrmc_pkg::MAC_W'(dig);
  assign lon_mac = nrmc_pkg::MAC_W'(lon_r) * nrmc_pkg::MAC_W'(10) + nrmc_pkg::MAC_W'(dig);
  assign lat_mac_sat = (lat_mac > nrmc_pkg::MAC_W'(nrmc_pkg::LAT_MAX)) ?
                       nrmc_pkg::LAT_MAX : lat_mac[nrmc_pkg::LAT_W-1:0];
  assign lon_mac_sat = (lon_mac > nrmc_pkg::MAC_W'(nrmc_pkg::LON_MAX)) ?
                       nrmc_pkg::LON_MAX : lon_mac[nrmc_pkg::LON_W-1:0];

  // a digit is accumulated in the integer part, or while fraction room remains
  assign num_take = is_digit && !stop_r &&
                    (!in_frac_r || (frac_r < nrmc_pkg::FRAC_W'(nrmc_pkg::FRAC_DIGITS)));

  always_comb begin
    line_pos_nxt  = line_pos_r;
    comma_nxt     = comma_r;
    field_off_nxt = field_off_r;
    type_c_nxt    = type_c_r;
    time_nxt      = time_r;
    date_nxt      = date_r;
    lat_nxt       = lat_r;
    lon_nxt       = lon_r;
    frac_nxt      = frac_r;
    in_frac_nxt   = in_frac_r;
    stop_nxt      = stop_r;
    ns_nxt        = ns_r;
    ew_nxt        = ew_r;

    if (fire && active) begin
      if (line_pos_r == nrmc_pkg::POS_W'(nrmc_pkg::TYPE_POS)) begin
        type_c_nxt = (in_byte == nrmc_pkg::CH_C);
      end
      for (int i = 0; i < nrmc_pkg::DIGITS; i++) begin
        if (line_pos_r == nrmc_pkg::POS_W'(nrmc_pkg::TIME_POS0 + i)) begin
          time_nxt[4*i +: 4] = dig;
        end
      end
      if (field_off_r == '0) begin
        if (comma_r == nrmc_pkg::NS_FIELD) ns_nxt = in_byte;
        if (comma_r == nrmc_pkg::EW_FIELD) ew_nxt = in_byte;
      end
      if (in_byte == nrmc_pkg::CH_COMMA) begin
        if (comma_r == nrmc_pkg::LAT_FIELD) lat_nxt = lat_scaled;
        if (comma_r == nrmc_pkg::LON_FIELD) lon_nxt = lon_scaled;
        if (comma_r < nrmc_pkg::COMMA_MAX) comma_nxt = comma_r + 4'd1;
        field_off_nxt = '0;
        frac_nxt      = '0;
        in_frac_nxt   = 1'b0;
        stop_nxt      = 1'b0;
      end else begin
        if (comma_r == nrmc_pkg::DATE_FIELD) begin
          for (int i = 0; i < nrmc_pkg::DIGITS; i++) begin
            if (field_off_r == nrmc_pkg::POS_W'(i)) date_nxt[4*i +: 4] = dig;
          end
        end
        if ((comma_r == nrmc_pkg::LAT_FIELD || comma_r == nrmc_pkg::LON_FIELD) && !stop_r)
        begin
          if (is_digit) begin
            if (num_take) begin
              if (comma_r == nrmc_pkg::LAT_FIELD) lat_nxt = lat_mac_sat;
              else                                lon_nxt = lon_mac_sat;
              if (in_frac_r) frac_nxt = frac_r + nrmc_pkg::FRAC_W'(1);
            end
          end else if (in_byte == nrmc_pkg::CH_DOT && !in_frac_r) begin
            in_frac_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        if (field_off_r < nrmc_pkg::POS_W'(nrmc_pkg::LINE_LIMIT)) begin
          field_off_nxt = field_off_r + nrmc_pkg::POS_W'(1);
        end
      end
    end

    // record is built from the state after this byte, then the line restarts
    q_push                = fire && (in_byte == nrmc_pkg::CH_LF) && type_c_nxt;
    q_rec.time_dig        = time_nxt;
    q_rec.date_dig        = date_nxt;
    q_rec.lat             = lat_nxt;
    q_rec.lon             = lon_nxt;
    q_rec.frac            = frac_nxt;
    q_rec.scale_lat       = (comma_nxt == nrmc_pkg::LAT_FIELD);
    q_rec.scale_lon       = (comma_nxt == nrmc_pkg::LON_FIELD);
    q_rec.ns              = ns_nxt;
    q_rec.ew              = ew_nxt;

    if (fire) begin
      if (in_byte == nrmc_pkg::CH_LF) begin
        line_pos_nxt  = '0;
        comma_nxt     = '0;
        field_off_nxt = '0;
        type_c_nxt    = 1'b0;
        time_nxt      = '0;
        date_nxt      = '0;
        lat_nxt       = '0;
        lon_nxt       = '0;
        frac_nxt      = '0;
        in_frac_nxt   = 1'b0;
        stop_nxt      = 1'b0;
        ns_nxt        = '0;
        ew_nxt        = '0;
      end else if (active) begin
        line_pos_nxt = line_pos_r + nrmc_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r  <= '0;
      comma_r     <= '0;
      field_off_r <= '0;
      type_c_r    <= 1'b0;
      time_r      <= '0;
      date_r      <= '0;
      lat_r       <= '0;
      lon_r       <= '0;
      frac_r      <= '0;
      in_frac_r   <= 1'b0;
      stop_r      <= 1'b0;
      ns_r        <= '0;
      ew_r        <= '0;
    end else begin
      line_pos_r  <= line_pos_nxt;
      comma_r     <= comma_nxt;
      field_off_r <= field_off_nxt;
      type_c_r    <= type_c_nxt;
      time_r      <= time_nxt;
      date_r      <= date_nxt;
      lat_r       <= lat_nxt;
      lon_r       <= lon_nxt;
      frac_r      <= frac_nxt;
      in_frac_r   <= in_frac_nxt;
      stop_r      <= stop_nxt;
      ns_r        <= ns_nxt;
      ew_r        <= ew_nxt;
    end
  end

endmodule

// ----- sv/nrmc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_fifo
// Two-entry record queue between the parser and the time/date unit.
// ----------------------------------------------------------------------------
module nrmc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrmc_pkg::rec_t wr_rec,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output nrmc_pkg::rec_t rd_rec
);

  nrmc_pkg::rec_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_rec  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/nrmc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_back
// Time/date unit: digit decode, pad-out, one-second add, zone shift, rollover.
// ----------------------------------------------------------------------------
module nrmc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rec_valid,
  output logic                            rec_pop,
  input  nrmc_pkg::rec_t                  rec,
  input  logic [4:0]                      zone_hours,
  input  logic                            add_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nrmc_pkg::OUT_W-1:0]      out_data
);

  typedef struct packed {
    logic [4:0]                 hour;
    logic [5:0]                 minute;
    logic [5:0]                 second;
    logic [4:0]                 day;
    logic [3:0]                 month;
    logic [6:0]                 yy;
    logic [nrmc_pkg::LAT_W-1:0] lat;
    logic [7:0]                 ns;
    logic [nrmc_pkg::LON_W-1:0] lon;
    logic [7:0]                 ew;
  } stage_t;

  stage_t                       st_r, st_nxt;
  logic                         st_valid_r;
  logic                         out_valid_r;
  logic [nrmc_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;
  logic                         out_en, st_en;

  logic [nrmc_pkg::LON_W-1:0]                   sc_op;
  logic [nrmc_pkg::LON_W+nrmc_pkg::SCALE_W-1:0] sc_prod;

  logic [5:0]  h6, day6;
  logic [4:0]  mon5;
  logic [11:0] year;
  logic        leap;

  assign out_en  = !out_valid_r || out_ready;
  assign st_en   = !st_valid_r || out_en;
  assign rec_pop = rec_valid && st_en;

  assign sc_op   = rec.scale_lat ? nrmc_pkg::LON_W'(rec.lat) : rec.lon;
  assign sc_prod = (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(sc_op) *
                   (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::frac_scale(rec.frac));

  // Stage 1: decode digits, finish an open position field, add one second if enabled
  always_comb begin
    st_nxt.hour   = 5'(nrmc_pkg::two_dig(rec.time_dig[3:0], rec.time_dig[7:4], 7'd23));
    st_nxt.minute = 6'(nrmc_pkg::two_dig(rec.time_dig[11:8], rec.time_dig[15:12], 7'd59));
    st_nxt.second = 6'(nrmc_pkg::two_dig(rec.time_dig[19:16], rec.time_dig[23:20], 7'd59));
    st_nxt.day    = 5'(nrmc_pkg::two_dig(rec.date_dig[3:0], rec.date_dig[7:4], 7'd31));
    st_nxt.month  = 4'(nrmc_pkg::two_dig(rec.date_dig[11:8], rec.date_dig[15:12], 7'd12));
    st_nxt.yy     = nrmc_pkg::two_dig(rec.date_dig[19:16], rec.date_dig[23:20], 7'd99);
    st_nxt.ns     = rec.ns;
    st_nxt.ew     = rec.ew;
    st_nxt.lat    = rec.lat;
    st_nxt.lon    = rec.lon;
    if (rec.scale_lat) begin
      st_nxt.lat = (sc_prod > (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::LAT_MAX)) ?
                   nrmc_pkg::LAT_MAX : sc_prod[nrmc_pkg::LAT_W-1:0];
    end
    if (rec.scale_lon) begin
      st_nxt.lon = (sc_prod > (nrmc_pkg::LON_W + nrmc_pkg::SCALE_W)'(nrmc_pkg::LON_MAX)) ?
                   nrmc_pkg::LON_MAX : sc_prod[nrmc_pkg::LON_W-1:0];
    end
    if (add_second) begin
      if (st_nxt.second == 6'd59) begin
        st_nxt.second = 6'd0;
        if (st_nxt.minute == 6'd59) begin
          st_nxt.minute = 6'd0;
          st_nxt.hour   = st_nxt.hour + 5'd1;   // may reach 24, handled below
        end else begin
          st_nxt.minute = st_nxt.minute + 6'd1;
        end
      end else begin
        st_nxt.second = st_nxt.second + 6'd1;
      end
    end
  end

  // Stage 2: zone shift with day/month/year rollover
  always_comb begin
    h6   = 6'(st_r.hour) + 6'(zone_hours);
    day6 = 6'(st_r.day);
    mon5 = 5'(st_r.month);
    year = nrmc_pkg::YEAR_BASE + 12'(st_r.yy);
    // years 2000..2099: every fourth is leap, 2000 included
    leap = (st_r.yy[1:0] == 2'd0);
    if (h6 > 6'd23) begin
      h6   = h6 - 6'd24;
      day6 = day6 + 6'd1;
      if (mon5 == 5'd4 || mon5 == 5'd6 || mon5 == 5'd9 || mon5 == 5'd11) begin
        if (day6 > 6'd30) begin
          day6 = 6'd1;
          mon5 = mon5 + 5'd1;
        end
      end else if (mon5 != 5'd2) begin
        if (day6 > 6'd31) begin
          day6 = 6'd1;
          mon5 = mon5 + 5'd1;
        end
      end
      if (mon5 == 5'd2 && day6 > (leap ? 6'd29 : 6'd28)) begin
        day6 = 6'd1;
        mon5 = mon5 + 5'd1;
      end
      if (mon5 > 5'd12) begin
        mon5 = mon5 - 5'd12;
        year = year + 12'd1;
      end
    end
    out_data_nxt = {1'b0, st_r.ew, st_r.lon, st_r.ns, st_r.lat, year, mon5[3:0],
                    day6[4:0], st_r.second, st_r.minute, h6[4:0]};
  end

  always_ff @(posedge clk) begin
    if (rec_pop) st_r <= st_nxt;
    if (out_en && st_valid_r) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_en)  st_valid_r  <= rec_valid;
      if (out_en) out_valid_r <= st_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/nmea_rmc_time_position_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_time_position_parser_top
// RMC sentence parser producing local time, date and scaled position.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received character per word in in_tdata. The parser accepts
//           a word each cycle while the two-entry record queue has room.
//   out_* : one 112-bit record per RMC line, released at its line feed.
//   cfg_* : write zone_hours (index 0, values above 23 clamp to 23) and
//           add_one_second (index 1) while the block is idle.
// Path: a record reaches out_tvalid after the line feed word is accepted, via
//   the queue write, then the decode stage, then the rollover/output stage.
// Throughput: one word per cycle while the queue has room; the parser updates
//   all line state per word and the time/date unit is a two-stage pipeline.
// Stall: when out_tready is low the output register holds its record, the
//   pipeline and queue fill, and in_tready drops only once two records wait
//   in the queue.
// Reset: rst_n (synchronous) clears line state, empties the queue and
//   pipeline, and loads zone_hours = 8, add_one_second = 1.
// ----------------------------------------------------------------------------
module nmea_rmc_time_position_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [21:17] day, [25:22] month,
  // [37:26] year, [64:38] latitude_e4, [72:65] north_south,
  // [102:73] longitude_e4, [110:103] east_west, [111] zero
  output logic [nrmc_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [nrmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [nrmc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [4:0]     zone_r, zone_nxt;
  logic           add_sec_r, add_sec_nxt;

  logic           q_push, q_full, q_valid, q_pop;
  nrmc_pkg::rec_t q_wr_rec, q_rd_rec;

  always_comb begin
    zone_nxt    = zone_r;
    add_sec_nxt = add_sec_r;
    if (cfg_wr_en) begin
      if (cfg_addr == nrmc_pkg::REG_ZONE_HOURS) begin
        zone_nxt = (cfg_wdata > nrmc_pkg::HOUR_MAX) ? nrmc_pkg::HOUR_MAX : cfg_wdata;
      end else if (cfg_addr == nrmc_pkg::REG_ADD_SECOND) begin
        add_sec_nxt = cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r    <= nrmc_pkg::ZONE_RESET;
      add_sec_r <= 1'b1;
    end else begin
      zone_r    <= zone_nxt;
      add_sec_r <= add_sec_nxt;
    end
  end

  nrmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_wr_rec)
  );

  nrmc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .full   (q_full),
    .valid  (q_valid),
    .pop    (q_pop),
    .rd_rec (q_rd_rec)
  );

  nrmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_valid),
    .rec_pop    (q_pop),
    .rec        (q_rd_rec),
    .zone_hours (zone_r),
    .add_second (add_sec_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

// ----- test/nmea_rmc_time_position_parser_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_time_position_parser_top_test
// Streams RMC sentences, broken lines and raw noise into the parser one
// character per word. A local sentence decoder tracks the line state and
// predicts every record. Records are checked field by field in order. Covers
// rollover, clamping, position scaling, register writes and random idling on
// both sides of the block.
// ----------------------------------------------------------------------------
module nmea_rmc_time_position_parser_top_test;
  import nrmc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS   = 120;
  localparam int PHASE_FIXES   = 2;

  typedef struct packed {
    logic [7:0]  east_west;
    logic [29:0] longitude_e4;
    logic [7:0]  north_south;
    logic [26:0] latitude_e4;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } fix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nmea_rmc_time_position_parser_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // decoder state
  int unsigned     zone_hr;
  int unsigned     add_sec;
  int unsigned     lpos, ncomma, foff, nfrac;
  bit              is_rmc, in_frac, num_done;
  bit [23:0]       tdig, ddig;
  longint unsigned lat_acc, lon_acc;
  logic [7:0]      ns_c, ew_c;

  fix_t fixes_due[$];
  int   mismatches = 0;
  int   chars_sent = 0;
  int   fixes_predicted = 0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;

  function automatic logic [3:0] char_val(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) ? 4'(c - CH_0) : 4'd0;
  endfunction

  function automatic longint unsigned mac10(input longint unsigned acc, input int unsigned d,
                                            input longint unsigned mx);
    longint unsigned v;
    v = acc * 10 + d;
    return (v > mx) ? mx : v;
  endfunction

  // pad missing fraction digits with zeros
  function automatic longint unsigned pad_frac(input longint unsigned acc,
                                               input longint unsigned mx);
    int k;
    for (k = nfrac; k < FRAC_DIGITS; k++) acc = mac10(acc, 0, mx);
    return acc;
  endfunction

  function automatic int unsigned clamp_pair(input bit [23:0] w, input int i,
                                             input int unsigned mx);
    int unsigned v;
    v = w[4*i +: 4] * 10 + w[4*i+4 +: 4];
    return (v > mx) ? mx : v;
  endfunction

  function automatic void start_number();
    nfrac = 0;
    in_frac = 1'b0;
    num_done = 1'b0;
  endfunction

  function automatic void clear_line();
    lpos = 0;
    ncomma = 0;
    foff = 0;
    is_rmc = 1'b0;
    tdig = '0;
    ddig = '0;
    lat_acc = 0;
    lon_acc = 0;
    ns_c = 8'd0;
    ew_c = 8'd0;
    start_number();
  endfunction

  function automatic void reset_decoder();
    zone_hr = ZONE_RESET;
    add_sec = 1;
    clear_line();
  endfunction

  // like atof: digits and one dot; anything else ends the number
  function automatic longint unsigned num_char(input longint unsigned acc,
                                               input logic [7:0] c,
                                               input longint unsigned mx);
    if (num_done) return acc;
    if (c >= CH_0 && c <= CH_9) begin
      if (!in_frac) begin
        acc = mac10(acc, c - CH_0, mx);
      end else if (nfrac < FRAC_DIGITS) begin
        acc = mac10(acc, c - CH_0, mx);
        nfrac++;
      end
    end else if (c == CH_DOT && !in_frac) begin
      in_frac = 1'b1;
    end else begin
      num_done = 1'b1;
    end
    return acc;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    if (lpos == TYPE_POS) is_rmc = (c == CH_C);
    if (lpos >= TIME_POS0 && lpos < TIME_POS0 + DIGITS)
      tdig[4*(lpos-TIME_POS0) +: 4] = char_val(c);
    if (foff == 0) begin
      if (ncomma == NS_FIELD) ns_c = c;
      if (ncomma == EW_FIELD) ew_c = c;
    end
    if (c == CH_COMMA) begin
      if (ncomma == LAT_FIELD) lat_acc = pad_frac(lat_acc, LAT_MAX);
      if (ncomma == LON_FIELD) lon_acc = pad_frac(lon_acc, LON_MAX);
      if (ncomma < COMMA_MAX) ncomma++;
      foff = 0;
      start_number();
      return;
    end
    if (ncomma == DATE_FIELD && foff < DIGITS) ddig[4*foff +: 4] = char_val(c);
    if (ncomma == LAT_FIELD) lat_acc = num_char(lat_acc, c, LAT_MAX);
    if (ncomma == LON_FIELD) lon_acc = num_char(lon_acc, c, LON_MAX);
    if (foff < LINE_LIMIT) foff++;
  endfunction

  function automatic fix_t build_fix();
    fix_t            f;
    int unsigned     h, m, s, d, mo, y;
    longint unsigned lat, lon;
    bit              leap;
    h  = clamp_pair(tdig, 0, 23);
    m  = clamp_pair(tdig, 2, 59);
    s  = clamp_pair(tdig, 4, 59);
    d  = clamp_pair(ddig, 0, 31);
    mo = clamp_pair(ddig, 2, 12);
    y  = clamp_pair(ddig, 4, 99) + YEAR_BASE;
    // line ended inside a coordinate field: finish its scaling here
    lat = (ncomma == LAT_FIELD) ? pad_frac(lat_acc, LAT_MAX) : lat_acc;
    lon = (ncomma == LON_FIELD) ? pad_frac(lon_acc, LON_MAX) : lon_acc;
    if (add_sec != 0) begin
      s++;
      if (s > 59) begin
        s = 0;
        m++;
        if (m > 59) begin
          m = 0;
          h++;
        end
      end
    end
    h += zone_hr;
    if (h > 23) begin
      h -= 24;
      d++;
      if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
        if (d > 30) begin
          d = 1;
          mo++;
        end
      end else if (mo != 2) begin
        if (d > 31) begin
          d = 1;
          mo++;
        end
      end
      leap = (y % 4 == 0) && (y % 400 == 0 || y % 100 != 0);
      if (mo == 2 && d > (leap ? 29 : 28)) begin
        d = 1;
        mo++;
      end
      if (mo > 12) begin
        mo -= 12;
        y++;
      end
    end
    f.hour         = 5'(h);
    f.minute       = 6'(m);
    f.second       = 6'(s);
    f.day          = 5'(d);
    f.month        = 4'(mo);
    f.year         = 12'(y);
    f.latitude_e4  = 27'(lat);
    f.north_south  = ns_c;
    f.longitude_e4 = 30'(lon);
    f.east_west    = ew_c;
    return f;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    if (lpos < LINE_LIMIT) take_char(c);
    if (c == CH_LF) begin
      if (is_rmc) begin
        fixes_due.push_back(build_fix());
        fixes_predicted++;
      end
      clear_line();
    end else if (lpos < LINE_LIMIT) begin
      lpos++;
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void check_fix(input logic [OUT_W-1:0] word);
    fix_t got, want;
    if (fixes_due.size() == 0) begin
      $error("record with no line pending: %h", word);
      mismatches++;
      return;
    end
    got  = fix_t'(word[OUT_BITS-1:0]);
    want = fixes_due.pop_front();
    cmp_field("hour", want.hour, got.hour);
    cmp_field("minute", want.minute, got.minute);
    cmp_field("second", want.second, got.second);
    cmp_field("day", want.day, got.day);
    cmp_field("month", want.month, got.month);
    cmp_field("year", want.year, got.year);
    cmp_field("latitude_e4", want.latitude_e4, got.latitude_e4);
    cmp_field("north_south", want.north_south, got.north_south);
    cmp_field("longitude_e4", want.longitude_e4, got.longitude_e4);
    cmp_field("east_west", want.east_west, got.east_west);
    cmp_field("pad", 32'd0, word[OUT_W-1]);
  endfunction

  // sample the result word first, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_fix(out_tdata);
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // all records out, then room for a line that ends without one
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (fixes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_ZONE_HOURS) zone_hr = (val > HOUR_MAX) ? HOUR_MAX : val;
    else if (idx == REG_ADD_SECOND) add_sec = val[0];
  endtask

  function automatic string rmc_line(input int hh, input int mm, input int ss,
                                     input int dd, input int mo, input int yy,
                                     input string lat, input string ns,
                                     input string lon, input string ew);
    return $sformatf("$GPRMC,%02d%02d%02d.00,A,%s,%s,%s,%s,0.4,77.5,%02d%02d%02d,,,A*5C\015\n",
                     hh, mm, ss, lat, ns, lon, ew, dd, mo, yy);
  endfunction

  function automatic string digits(input int n);
    string s;
    int    i;
    s = "";
    for (i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
    return s;
  endfunction

  function automatic string junk_text();
    int r;
    r = $urandom_range(4);
    case (r)
      0: return "-";
      1: return " ";
      2: return ".";
      3: return "+";
      default: return "E";
    endcase
  endfunction

  function automatic string rand_coord(input int nom);
    string s;
    int    n_int, n_frac, spot;
    n_int  = ($urandom_range(9) < 7) ? nom : $urandom_range(nom + 7);
    n_frac = ($urandom_range(3) == 0) ? $urandom_range(7) : FRAC_DIGITS;
    spot   = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
    s = "";
    if (spot == 0) s = {s, junk_text()};
    s = {s, digits(n_int)};
    if (spot == 1) s = {s, junk_text()};
    if ($urandom_range(9) != 0) s = {s, ".", digits(n_frac)};
    if (spot == 2) s = {s, junk_text(), digits(2)};
    return s;
  endfunction

  function automatic string rand_hemi(input string a, input string b);
    int r;
    r = $urandom_range(9);
    if (r < 4) return a;
    if (r < 8) return b;
    if (r == 8) return "";
    return "Q";
  endfunction

  function automatic int rand_hour();
    int r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(23);
    if (r < 8) return $urandom_range(23, 15);
    if (r == 8) return $urandom_range(99);
    return 23;
  endfunction

  function automatic int rand_min_sec();
    int r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(59);
    if (r < 9) return 59;
    return $urandom_range(99);
  endfunction

  function automatic int rand_day();
    int r;
    r = $urandom_range(9);
    if (r < 4) return $urandom_range(31, 1);
    if (r < 8) return $urandom_range(31, 27);
    if (r == 8) return $urandom_range(99);
    return 0;
  endfunction

  function automatic int rand_month();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(12, 1);
    if (r == 5) return 2;
    if (r == 6) return 12;
    if (r == 7) return 4;
    return $urandom_range(99);
  endfunction

  function automatic int rand_year();
    int r;
    r = $urandom_range(4);
    if (r == 0) return 0;
    if (r == 1) return 99;
    return $urandom_range(99);
  endfunction

  function automatic string rand_rmc();
    return rmc_line(rand_hour(), rand_min_sec(), rand_min_sec(), rand_day(),
                    rand_month(), rand_year(), rand_coord(4), rand_hemi("N", "S"),
                    rand_coord(5), rand_hemi("E", "W"));
  endfunction

  task automatic send_random_line();
    int    kind, n, i, k;
    string s;
    kind = $urandom_range(99);
    if (kind < 78) begin
      send_text(rand_rmc());
    end else if (kind < 87) begin
      // sentence cut short
      s = rand_rmc();
      k = $urandom_range(s.len() - 3, 1);
      send_text(s.substr(0, k - 1));
      send_char(CH_LF);
    end else if (kind < 94) begin
      n = $urandom_range(40, 1);
      for (i = 0; i < n; i++) send_char(8'($urandom_range(255)));
      if ($urandom_range(9) < 7) send_char(CH_LF);
    end else begin
      send_text($sformatf("$GPGGA,%02d%02d%02d,4807.038,N,01131.000,E,1,08,0.9,M*47\015\n",
                          rand_hour(), rand_min_sec(), rand_min_sec()));
    end
  endtask

  task automatic test_time_and_date();
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\015\n");
    send_text(rmc_line(23, 59, 59, 31, 12, 99, "4807.038", "N", "01131.000", "E"));
    // non-leap February, then leap years
    send_text(rmc_line(15, 59, 59, 28, 2, 1, "0000.0000", "S", "00000.0000", "W"));
    send_text(rmc_line(16, 0, 0, 28, 2, 0, "1234.5678", "N", "12345.6789", "E"));
    send_text(rmc_line(20, 0, 0, 29, 2, 4, "5959.9999", "S", "17959.9999", "W"));
    send_text(rmc_line(16, 30, 0, 30, 4, 23, "0001.0001", "N", "00001.0001", "E"));
    // out-of-range values clamp
    send_text(rmc_line(99, 99, 99, 99, 99, 99, "9999.9999", "N", "99999.9999", "E"));
    // non-digits in time, day and month of zero
    send_text("$GPRMC,1x3Y5z.00,A,4807.038,N,01131.000,E,0.0,0.0,000000,,,A*00\015\n");
    send_text(rmc_line(20, 0, 0, 0, 0, 0, "4807", "N", "01131", "E"));
    // too few commas, short date field
    send_text("$GPRMC,123456\015\n");
    send_text("$GPRMC,010203,A,,,,,,,0312,\015\n");
    send_text("\n");
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n");
  endtask

  task automatic test_position_fields();
    // overflow saturates, empty hemispheres take the next byte
    send_text(rmc_line(1, 2, 3, 4, 5, 6, "12345678.99999", "", "999999999999.9", ""));
    // sign, second dot, surplus fraction digits
    send_text(rmc_line(7, 8, 9, 10, 11, 12, "-4807.038", "S", "01131.00.5", "W"));
    send_text(rmc_line(7, 8, 9, 10, 11, 12, "4807.0380123", "N", " 01131", "E"));
    send_text(rmc_line(13, 14, 15, 16, 1, 50, "4807", "S", ".5", "W"));
    // line ends inside a coordinate or a hemisphere field
    send_text("$GPRMC,120000,A,4807.03\n");
    send_text("$GPRMC,120000,A,4807.03,N,0113\n");
    send_text("$GPRMC,120000,A,4807,\015\n");
    send_text("$GPRMC,,,,,,,,,,,,,,,,,,,,\n");
  endtask

  task automatic test_overlong_line();
    int         i;
    logic [7:0] c;
    send_text("$GPRMC,");
    for (i = 0; i < LINE_LIMIT + 8; i++) begin
      c = 8'($urandom_range(255));
      if (c == CH_LF) c = CH_COMMA;
      send_char(c);
    end
    send_char(CH_LF);
    send_text(rmc_line(11, 22, 33, 15, 6, 25, "4807.038", "N", "01131.000", "E"));
  endtask

  task automatic test_register_writes();
    write_reg(REG_ZONE_HOURS, 5'd31);
    write_reg(REG_ADD_SECOND, 5'b00010);
    send_text(rmc_line(23, 59, 59, 31, 12, 99, "4807.038", "N", "01131.000", "E"));
    send_text(rmc_line(0, 0, 0, 1, 1, 0, "4807.038", "N", "01131.000", "E"));
    // spare indexes must not disturb either register
    write_reg(REG_SPARE_2, 5'h1F);
    write_reg(REG_SPARE_3, 5'h00);
    send_text(rmc_line(5, 0, 0, 30, 11, 10, "4807.038", "S", "01131.000", "W"));
    write_reg(REG_ZONE_HOURS, 5'd0);
    write_reg(REG_ADD_SECOND, 5'b11111);
    send_text(rmc_line(23, 59, 59, 28, 2, 96, "4807.038", "N", "01131.000", "E"));
    send_text(rmc_line(23, 59, 59, 31, 1, 21, "4807.038", "N", "01131.000", "E"));
  endtask

  task automatic run_traffic(input int idle_pct, input int stall_pct,
                             input logic [CFG_DATA_W-1:0] zone,
                             input logic [CFG_DATA_W-1:0] add1);
    int chars0, fixes0;
    write_reg(REG_ZONE_HOURS, zone);
    write_reg(REG_ADD_SECOND, add1);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    chars0 = chars_sent;
    fixes0 = fixes_predicted;
    while (chars_sent - chars0 < PHASE_CHARS || fixes_predicted - fixes0 < PHASE_FIXES)
      send_random_line();
  endtask

  task automatic test_random_traffic();
    run_traffic(0, 0, ZONE_RESET, 5'd1);
    run_traffic(47, 0, HOUR_MAX, 5'd0);
    run_traffic(0, 47, 5'd0, 5'd1);
    run_traffic(32, 32, 5'($urandom_range(31)), 5'($urandom_range(31)));
    in_idle_pct   = 0;
    out_stall_pct = 0;
  endtask

  initial begin
    reset_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_time_and_date();
    test_position_fields();
    test_overlong_line();
    test_register_writes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && fixes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/nrmc_pkg.sv
sv/nrmc_front.sv
sv/nrmc_fifo.sv
sv/nrmc_back.sv
sv/nmea_rmc_time_position_parser_top.sv
test/nmea_rmc_time_position_parser_top_test.sv
